>>> design/rne_pkg.sv
`default_nettype none
package rne_pkg;

	localparam int unsigned ValueWidth = 12;
	localparam int unsigned CharWidth = 8;
	localparam int unsigned TokenCount = 13;
	localparam int unsigned TokenIdxWidth = $clog2(TokenCount);
	localparam logic [ValueWidth-1:0] MaxValue = 12'd3999;

	typedef logic [ValueWidth-1:0] value_t;
	typedef logic [CharWidth-1:0] char_t;
	typedef logic [TokenIdxWidth-1:0] token_idx_t;

	typedef struct packed {
		logic ge;
		logic zero;
	} cmp_flags_t;

	function automatic value_t token_weight(input token_idx_t idx);
		value_t w;
		unique case (idx)
			4'd0: w = 12'd1000;
			4'd1: w = 12'd900;
			4'd2: w = 12'd500;
			4'd3: w = 12'd400;
			4'd4: w = 12'd100;
			4'd5: w = 12'd90;
			4'd6: w = 12'd50;
			4'd7: w = 12'd40;
			4'd8: w = 12'd10;
			4'd9: w = 12'd9;
			4'd10: w = 12'd5;
			4'd11: w = 12'd4;
			default: w = 12'd1;
		endcase
		return w;
	endfunction

	function automatic char_t token_first(input token_idx_t idx);
		char_t c;
		unique case (idx)
			4'd0: c = "M";
			4'd1: c = "C";
			4'd2: c = "D";
			4'd3: c = "C";
			4'd4: c = "C";
			4'd5: c = "X";
			4'd6: c = "L";
			4'd7: c = "X";
			4'd8: c = "X";
			4'd9: c = "I";
			4'd10: c = "V";
			4'd11: c = "I";
			default: c = "I";
		endcase
		return c;
	endfunction

	function automatic char_t token_second(input token_idx_t idx);
		char_t c;
		unique case (idx)
			4'd1: c = "M";
			4'd3: c = "D";
			4'd5: c = "C";
			4'd7: c = "L";
			4'd9: c = "X";
			4'd11: c = "V";
			default: c = 8'd0;
		endcase
		return c;
	endfunction

	function automatic logic token_pair(input token_idx_t idx);
		return idx[0];
	endfunction

endpackage
`default_nettype wire

>>> design/rne_cmp_sub.sv
`default_nettype none
module rne_cmp_sub (
	input wire rne_pkg::value_t a,
	input wire rne_pkg::value_t b,
	output rne_pkg::value_t diff,
	output rne_pkg::cmp_flags_t flags
);

	logic [rne_pkg::ValueWidth:0] wide_diff;

	assign wide_diff = {1'b0, a} - {1'b0, b};
	assign diff = wide_diff[rne_pkg::ValueWidth-1:0];
	assign flags.ge = ~wide_diff[rne_pkg::ValueWidth];
	assign flags.zero = (wide_diff == '0);

endmodule
`default_nettype wire

>>> design/roman_numeral_encoder.sv
// Order: a bad value's strobe is registered at the same edge that takes start; the first letter
// strobes once the scan reaches the first token whose weight fits, passing those that do not.
// A bad value never raises busy, so a new request can follow it; a valid request holds busy.
// A compare-subtract unit walks 13 tokens greedily, one compare per cycle; StSecond emits pair tails.
// Busy stays high until the cycle that produces the final letter; results cannot be stalled.
// Reset: arst_n clears the sequencer and the strobe; letter registers are not reset.
`default_nettype none
module roman_numeral_encoder (
	input wire clk,
	input wire arst_n,
	input wire start,
	output logic busy,
	input wire [11:0] value,
	output logic strobe,
	output logic [7:0] char_code,
	output logic char_valid,
	output logic last,
	output logic bad_value
);

	localparam logic [1:0] StIdle = 2'd0;
	localparam logic [1:0] StScan = 2'd1;
	localparam logic [1:0] StSecond = 2'd2;

	logic [1:0] state_q;
	rne_pkg::value_t rem_q;
	rne_pkg::token_idx_t idx_q;
	logic strobe_q;
	rne_pkg::char_t char_q;
	logic valid_q;
	logic last_q;
	logic bad_q;

	rne_pkg::value_t diff;
	rne_pkg::cmp_flags_t flags;
	logic rem_zero;
	logic accept;
	logic out_of_range;

	rne_cmp_sub u_cmp_sub (
		.a(rem_q),
		.b(rne_pkg::token_weight(idx_q)),
		.diff(diff),
		.flags(flags)
	);

	assign rem_zero = (rem_q == '0);
	assign busy = (state_q != StIdle);
	assign accept = start & ~busy;
	assign out_of_range = (value == '0) || (value > rne_pkg::MaxValue);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				StIdle: begin
					if (accept) begin
						if (out_of_range) begin
							strobe_q <= 1'b1;
						end else begin
							state_q <= StScan;
						end
					end
				end
				StScan: begin
					if (flags.ge) begin
						strobe_q <= 1'b1;
						if (rne_pkg::token_pair(idx_q)) begin
							state_q <= StSecond;
						end else if (flags.zero) begin
							state_q <= StIdle;
						end
					end
				end
				StSecond: begin
					strobe_q <= 1'b1;
					state_q <= rem_zero ? StIdle : StScan;
				end
				default: begin
					state_q <= StIdle;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			StIdle: begin
				if (accept) begin
					rem_q <= value;
					idx_q <= '0;
					char_q <= 8'd0;
					valid_q <= 1'b0;
					last_q <= 1'b1;
					bad_q <= 1'b1;
				end
			end
			StScan: begin
				char_q <= rne_pkg::token_first(idx_q);
				valid_q <= 1'b1;
				bad_q <= 1'b0;
				last_q <= flags.zero & ~rne_pkg::token_pair(idx_q);
				if (flags.ge) begin
					rem_q <= diff;
				end else begin
					idx_q <= idx_q + rne_pkg::token_idx_t'(1);
				end
			end
			StSecond: begin
				char_q <= rne_pkg::token_second(idx_q);
				valid_q <= 1'b1;
				bad_q <= 1'b0;
				last_q <= rem_zero;
				idx_q <= idx_q + rne_pkg::token_idx_t'(1);
			end
			default: begin
				idx_q <= '0;
			end
		endcase
	end

	assign strobe = strobe_q;
	assign char_code = char_q;
	assign char_valid = valid_q;
	assign last = last_q;
	assign bad_value = bad_q;

endmodule
`default_nettype wire

>>> sim/tb.sv
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CycleLimit = 100000;
	localparam int unsigned RandomRequests = 86;
	localparam int unsigned ReportLimit = 10;
	localparam rne_pkg::char_t LetterM = "M";
	localparam rne_pkg::char_t LetterD = "D";
	localparam rne_pkg::char_t LetterC = "C";
	localparam rne_pkg::char_t LetterL = "L";
	localparam rne_pkg::char_t LetterX = "X";
	localparam rne_pkg::char_t LetterV = "V";
	localparam rne_pkg::char_t LetterI = "I";
	localparam rne_pkg::char_t NoLetter = 8'd0;

	typedef struct packed {
		rne_pkg::char_t code;
		logic valid;
		logic last;
		logic bad;
	} numeral_letter_t;

	typedef struct {
		rne_pkg::value_t v;
		bit drain;
	} request_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [11:0] value = '0;
	logic busy;
	logic strobe;
	logic [7:0] char_code;
	logic char_valid;
	logic last;
	logic bad_value;

	request_t pending_values[$];
	numeral_letter_t expected_letters[$];
	request_t next_req;
	numeral_letter_t got_letter;
	numeral_letter_t want_letter;
	int unsigned gap_left = 0;
	int unsigned calm_left = 0;
	int unsigned cycles = 0;
	int unsigned mismatches = 0;
	int unsigned requests_sent = 0;
	int unsigned bad_requests = 0;
	int unsigned letters_seen = 0;
	int unsigned run_len = 0;
	int unsigned longest_run = 0;

	roman_numeral_encoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.value(value),
		.strobe(strobe),
		.char_code(char_code),
		.char_valid(char_valid),
		.last(last),
		.bad_value(bad_value)
	);

	always #5 clk = ~clk;

	function automatic void add_letter(input rne_pkg::char_t c);
		expected_letters.push_back('{code: c, valid: 1'b1, last: 1'b0, bad: 1'b0});
	endfunction

	function automatic void predict_numeral(input rne_pkg::value_t v);
		int unsigned digit [4];
		int unsigned rest;
		rne_pkg::char_t one;
		rne_pkg::char_t five;
		rne_pkg::char_t ten;
		if (v == 0 || v > rne_pkg::MaxValue) begin
			expected_letters.push_back('{code: NoLetter, valid: 1'b0, last: 1'b1, bad: 1'b1});
			bad_requests++;
			return;
		end
		rest = v;
		for (int p = 3; p >= 0; p--) begin
			digit[p] = rest % 10;
			rest = rest / 10;
		end
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin
					one = LetterM;
					five = NoLetter;
					ten = NoLetter;
				end
				1: begin
					one = LetterC;
					five = LetterD;
					ten = LetterM;
				end
				2: begin
					one = LetterX;
					five = LetterL;
					ten = LetterC;
				end
				default: begin
					one = LetterI;
					five = LetterV;
					ten = LetterX;
				end
			endcase
			case (digit[p])
				1, 2, 3: begin
					repeat (digit[p]) add_letter(one);
				end
				4: begin
					add_letter(one);
					add_letter(five);
				end
				5, 6, 7, 8: begin
					add_letter(five);
					repeat (digit[p] - 5) add_letter(one);
				end
				9: begin
					add_letter(one);
					add_letter(ten);
				end
				default: ;
			endcase
		end
		expected_letters[expected_letters.size() - 1].last = 1'b1;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 6) begin
			calm_left = $urandom_range(5, 15);
			return 0;
		end
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic rne_pkg::value_t long_numeral();
		int unsigned heavy [5] = '{3, 4, 7, 8, 9};
		return rne_pkg::value_t'($urandom_range(0, 3) * 1000
			+ heavy[$urandom_range(0, 4)] * 100
			+ heavy[$urandom_range(0, 4)] * 10 + heavy[$urandom_range(0, 4)]);
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				expected_letters.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				predict_numeral(value);
				requests_sent++;
				gap_left = pick_gap();
			end
			if (start && busy) begin
				// hold the request until the block takes it
			end else if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_values.size() != 0
					&& !(pending_values[0].drain && expected_letters.size() != 0)) begin
				next_req = pending_values.pop_front();
				start <= 1'b1;
				value <= next_req.v;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			got_letter = '{code: char_code, valid: char_valid, last: last, bad: bad_value};
			if (char_valid) letters_seen++;
			run_len++;
			if (last) begin
				if (run_len > longest_run) longest_run = run_len;
				run_len = 0;
			end
			if (expected_letters.size() == 0) begin
				mismatches++;
				if (mismatches <= ReportLimit) begin
					$display("unexpected result: code %h valid %b last %b bad %b",
						char_code, char_valid, last, bad_value);
				end
			end else begin
				want_letter = expected_letters.pop_front();
				if (got_letter !== want_letter) begin
					mismatches++;
					if (mismatches <= ReportLimit) begin
						$display("mismatch: expected code %h valid %b last %b bad %b,",
							want_letter.code, want_letter.valid, want_letter.last,
							want_letter.bad, " got code %h valid %b last %b bad %b",
							got_letter.code, got_letter.valid,
							got_letter.last, got_letter.bad);
					end
				end
			end
		end
	end

	initial begin
		rne_pkg::value_t directed [24] = '{12'd1, 12'd3999, 12'd3888, 12'd0, 12'd4000,
			12'd4095, 12'd4, 12'd9, 12'd40, 12'd90, 12'd400, 12'd900, 12'd1994, 12'd2444,
			12'd3749, 12'd1666, 12'd2048, 12'd14, 12'd49, 12'd3000, 12'd500,
			12'd3567, 12'd2730, 12'd1};
		rne_pkg::value_t v;
		int unsigned r;
		foreach (directed[i]) begin
			pending_values.push_back('{v: directed[i], drain: (i == 12)});
		end
		for (int i = 0; i < RandomRequests; i++) begin
			r = $urandom_range(0, 99);
			if (r < 8) v = rne_pkg::value_t'($urandom_range(4000, 4095));
			else if (r < 10) v = '0;
			else if (r < 30) v = long_numeral();
			else v = rne_pkg::value_t'($urandom_range(1, 3999));
			pending_values.push_back('{v: v, drain: (i % 30 == 29)});
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_values.size() != 0 || start || expected_letters.size() != 0) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);
		$display("run covered %0d requests (%0d out of range) and %0d letters", requests_sent,
			bad_requests, letters_seen);
		$display("longest numeral seen: %0d letters, mismatches: %0d", longest_run,
			mismatches);
		if (mismatches == 0 && expected_letters.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
`default_nettype wire
